FILE: design/cgl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and pipeline payload types for the color gradient lookup.
package cgl_pkg;

  // Field and register widths fixed by the register map.
  localparam int POS_W       = 17;
  localparam int LEN_W       = 17;
  localparam int NUM_SEGS    = 3;
  localparam int SUM_W       = LEN_W + 2;
  localparam int LENGTHS_W   = NUM_SEGS * LEN_W;
  localparam int COLORS_W    = 64;
  localparam int RGBA_W      = 32;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int SEG_W       = 2;
  localparam int COUNT_W     = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_STOPS     = 4;
  localparam int DEF_FRACTION_BITS = 16;

  // Register reset values.
  localparam logic [LENGTHS_W-1:0] LENGTHS_RESET = LENGTHS_W'(65536);
  localparam logic [COUNT_W-1:0]   COUNT_RESET   = COUNT_W'(1);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLORS_LOW,
    REG_COLORS_HIGH,
    REG_LENGTHS,
    REG_STOP_COUNT
  } cfg_reg_t;

  // Segment choice and fraction override that travel with each transaction.
  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic             force_frac;
    logic             force_one;
  } cgl_ctl_t;

  // Output of the segment search: control plus the division operands.
  typedef struct packed {
    cgl_ctl_t         ctl;
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] len;
  } cgl_sel_t;

endpackage

FILE: design/cgl_seg_select.sv
`timescale 1ns / 1ps
// Segment search stage: picks the segment for a position and the division operands.
module cgl_seg_select #(
  parameter int MAX_STOPS = cgl_pkg::DEF_MAX_STOPS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cgl_pkg::LENGTHS_W-1:0] transition_lengths,
  input  logic [cgl_pkg::COUNT_W-1:0]   stop_count,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cgl_pkg::POS_W-1:0]     position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cgl_pkg::cgl_sel_t             sel
);
  import cgl_pkg::*;

  localparam int SEGS_MAX = MAX_STOPS - 1;

  logic [COUNT_W-1:0] stops;
  logic [COUNT_W-1:0] segs;
  cgl_sel_t           sel_next;
  logic               en;

  // Clamp the stop count into the supported range.
  always_comb begin
    stops = stop_count;
    if (stop_count == '0) begin
      stops = COUNT_W'(1);
    end else if (stop_count > COUNT_W'(MAX_STOPS)) begin
      stops = COUNT_W'(MAX_STOPS);
    end
    segs = stops - COUNT_W'(1);
  end

  // Walk the running sums; the first one that reaches the position wins.
  // With no hit the last segment is used at full fraction.
  always_comb begin
    logic [SUM_W-1:0] base_sum;
    logic [SUM_W-1:0] reach;
    logic [LEN_W-1:0] l;
    logic             found;
    base_sum               = '0;
    reach                  = '0;
    l                      = '0;
    found                  = 1'b0;
    sel_next               = '0;
    sel_next.ctl.seg       = SEG_W'(segs - COUNT_W'(1));
    sel_next.ctl.force_frac = 1'b1;
    sel_next.ctl.force_one = 1'b1;
    for (int k = 0; k < SEGS_MAX; k++) begin
      l     = transition_lengths[k*LEN_W +: LEN_W];
      reach = base_sum + SUM_W'(l);
      if (!found && (COUNT_W'(k) < segs) && (reach >= SUM_W'(position))) begin
        found                   = 1'b1;
        sel_next.ctl.seg        = SEG_W'(k);
        sel_next.offset         = LEN_W'(SUM_W'(position) - base_sum);
        sel_next.len            = l;
        sel_next.ctl.force_frac = (l == '0);
        sel_next.ctl.force_one  = 1'b0;
      end
      base_sum = reach;
    end
    // A single stop returns stop zero as it is.
    if (stops == COUNT_W'(1)) begin
      sel_next.ctl.seg        = '0;
      sel_next.ctl.force_frac = 1'b1;
      sel_next.ctl.force_one  = 1'b0;
    end
  end

  // Stage register.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      sel <= sel_next;
    end
  end

  // A real division always has a nonzero divisor and an offset inside the segment.
  a_div_operands: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sel.ctl.force_frac |-> (sel.len != '0) && (sel.offset <= sel.len))
    else $error("segment offset outside its segment");

  // The chosen segment always ends at a stop in use.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sel.ctl.seg <= SEG_W'(MAX_STOPS - 2))
    else $error("segment index beyond the last stop");

endmodule

FILE: design/cgl_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one fraction bit per stage.
module cgl_divider #(
  parameter int FRACTION_BITS = cgl_pkg::DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  cgl_pkg::cgl_sel_t      sel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cgl_pkg::cgl_ctl_t      ctl,
  output logic [FRACTION_BITS:0] quotient
);
  import cgl_pkg::*;

  localparam int STEPS = FRACTION_BITS + 1;
  localparam int QW    = FRACTION_BITS + 1;
  localparam logic [QW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [STEPS-1:0] v;
  logic [STEPS-1:0] en;
  logic [LEN_W-1:0] rem   [STEPS];
  logic [LEN_W-1:0] len_q [STEPS];
  logic [QW-1:0]    q     [STEPS];
  cgl_ctl_t         ctl_q [STEPS];

  // Each stage compares the shifted remainder against the divisor once.
  // The first stage handles the integer bit, since the offset never exceeds the divisor.
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [LEN_W:0]   r_in;
    logic [LEN_W:0]   diff;
    logic             ge;
    logic [QW-1:0]    q_in;
    logic [LEN_W-1:0] l_in;
    cgl_ctl_t         c_in;
    logic             up_valid;
    logic             down_stall;

    if (j == 0) begin : g_first
      assign r_in     = {1'b0, sel.offset};
      assign q_in     = '0;
      assign l_in     = sel.len;
      assign c_in     = sel.ctl;
      assign up_valid = in_valid;
    end else begin : g_next
      assign r_in     = {rem[j-1], 1'b0};
      assign q_in     = q[j-1];
      assign l_in     = len_q[j-1];
      assign c_in     = ctl_q[j-1];
      assign up_valid = v[j-1];
    end

    if (j == STEPS - 1) begin : g_last
      assign down_stall = out_stall;
    end else begin : g_mid
      assign down_stall = !en[j+1];
    end

    assign ge    = r_in >= {1'b0, l_in};
    assign diff  = r_in - {1'b0, l_in};
    assign en[j] = !v[j] || !down_stall;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= up_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j] && up_valid) begin
        rem[j]   <= ge ? diff[LEN_W-1:0] : r_in[LEN_W-1:0];
        q[j]     <= {q_in[QW-2:0], ge};
        len_q[j] <= l_in;
        ctl_q[j] <= c_in;
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[STEPS-1];
  assign quotient  = q[STEPS-1];
  assign ctl       = ctl_q[STEPS-1];

  // Offset at most the divisor keeps the quotient at or below one.
  a_quot_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ctl.force_frac |-> quotient <= ONE)
    else $error("fraction above one");

  // After the integer step the remainder sits below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[0] && !ctl_q[0].force_frac |-> rem[0] < len_q[0])
    else $error("remainder not reduced below divisor");

endmodule

FILE: design/cgl_blend.sv
`timescale 1ns / 1ps
// Color blend: per-channel weighted mix of the two segment end colors, two stages.
module cgl_blend #(
  parameter int FRACTION_BITS = cgl_pkg::DEF_FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cgl_pkg::cgl_ctl_t            ctl,
  input  logic [FRACTION_BITS:0]       quotient,
  input  logic [cgl_pkg::COLORS_W-1:0] stop_colors_low,
  input  logic [cgl_pkg::COLORS_W-1:0] stop_colors_high,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cgl_pkg::CH_W-1:0]     red,
  output logic [cgl_pkg::CH_W-1:0]     green,
  output logic [cgl_pkg::CH_W-1:0]     blue,
  output logic [cgl_pkg::CH_W-1:0]     alpha
);
  import cgl_pkg::*;

  localparam int QW     = FRACTION_BITS + 1;
  localparam int PROD_W = CH_W + QW;
  localparam logic [QW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // Stop k: bit 1 picks the register, bit 0 the half.
  function automatic logic [RGBA_W-1:0] stop_rgba(input logic [COLORS_W-1:0] lo,
                                                  input logic [COLORS_W-1:0] hi,
                                                  input logic [SEG_W-1:0]    k);
    logic [COLORS_W-1:0] word;
    word = k[1] ? hi : lo;
    return k[0] ? word[COLORS_W-1 -: RGBA_W] : word[RGBA_W-1:0];
  endfunction

  logic [QW-1:0]     frac;
  logic [QW-1:0]     frac_inv;
  logic [RGBA_W-1:0] color_a;
  logic [RGBA_W-1:0] color_b;
  logic              v1;
  logic              en1;
  logic              en2;
  logic [PROD_W-1:0] pa [NUM_CH];
  logic [PROD_W-1:0] pb [NUM_CH];
  logic [CH_W-1:0]   mix [NUM_CH];
  logic [CH_W-1:0]   color_q [NUM_CH];

  // Resolve the fraction, applying the overrides and the clamp at one.
  always_comb begin
    if (ctl.force_frac) begin
      frac = ctl.force_one ? ONE : '0;
    end else begin
      frac = (quotient > ONE) ? ONE : quotient;
    end
    frac_inv = ONE - frac;
    color_a  = stop_rgba(stop_colors_low, stop_colors_high, ctl.seg);
    color_b  = stop_rgba(stop_colors_low, stop_colors_high, ctl.seg + SEG_W'(1));
  end

  // Handshake: each stage loads when it is empty or the stage after it is moving.
  assign en2      = !out_valid || !out_stall;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        out_valid <= v1;
      end
    end
  end

  // Stage one: the two products per channel, red in the top byte.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      for (int c = 0; c < NUM_CH; c++) begin
        pa[c] <= PROD_W'(color_a[RGBA_W - CH_W*(c+1) +: CH_W]) * PROD_W'(frac_inv);
        pb[c] <= PROD_W'(color_b[RGBA_W - CH_W*(c+1) +: CH_W]) * PROD_W'(frac);
      end
    end
  end

  // Stage two: sum and drop the fraction bits, truncating.
  always_comb begin
    logic [PROD_W:0] s;
    s = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      s      = {1'b0, pa[c]} + {1'b0, pb[c]};
      mix[c] = s[FRACTION_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int c = 0; c < NUM_CH; c++) begin
        color_q[c] <= mix[c];
      end
    end
  end

  assign red   = color_q[0];
  assign green = color_q[1];
  assign blue  = color_q[2];
  assign alpha = color_q[3];

endmodule

FILE: design/color_gradient_lookup_core.sv
`timescale 1ns / 1ps
// Multi-stop linear color gradient lookup: configuration registers and the pipeline.
//
// Each position transaction returns one RGBA color. The block takes one position every
// clock when nothing stalls and returns colors in order, through the segment search
// register, the pipelined divider (one fraction bit per stage) and the blend (multiply,
// then add into the output register). Every stage moves on its own, so a stalled output
// only holds back items behind it once the stages up to it are full, and bubbles close
// up. Configuration writes take effect at once and belong in idle time between
// transactions; there is no start-up sweep after reset.
module color_gradient_lookup_core #(
  parameter int MAX_STOPS     = cgl_pkg::DEF_MAX_STOPS,
  parameter int FRACTION_BITS = cgl_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cgl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cgl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [cgl_pkg::POS_W-1:0]      position,
  input  logic                           position_valid,
  output logic                           position_stall,
  output logic [cgl_pkg::CH_W-1:0]       red,
  output logic [cgl_pkg::CH_W-1:0]       green,
  output logic [cgl_pkg::CH_W-1:0]       blue,
  output logic [cgl_pkg::CH_W-1:0]       alpha,
  output logic                           color_valid,
  input  logic                           color_stall
);
  import cgl_pkg::*;

  logic [COLORS_W-1:0]  stop_colors_low;
  logic [COLORS_W-1:0]  stop_colors_high;
  logic [LENGTHS_W-1:0] transition_lengths;
  logic [COUNT_W-1:0]   stop_count;

  logic                 sel_valid;
  logic                 sel_stall;
  cgl_sel_t             sel;
  logic                 div_valid;
  logic                 div_stall;
  cgl_ctl_t             div_ctl;
  logic [FRACTION_BITS:0] div_quotient;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_colors_low    <= '0;
      stop_colors_high   <= '0;
      transition_lengths <= LENGTHS_RESET;
      stop_count         <= COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLORS_LOW:  stop_colors_low    <= cfg_data;
        REG_COLORS_HIGH: stop_colors_high   <= cfg_data;
        REG_LENGTHS:     transition_lengths <= cfg_data[LENGTHS_W-1:0];
        REG_STOP_COUNT:  stop_count         <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Segment search.
  cgl_seg_select #(
    .MAX_STOPS(MAX_STOPS)
  ) u_select (
    .clk                (clk),
    .rst                (rst),
    .transition_lengths (transition_lengths),
    .stop_count         (stop_count),
    .in_valid           (position_valid),
    .in_stall           (position_stall),
    .position           (position),
    .out_valid          (sel_valid),
    .out_stall          (sel_stall),
    .sel                (sel)
  );

  // Fraction of the offset within its segment.
  cgl_divider #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_stall  (sel_stall),
    .sel       (sel),
    .out_valid (div_valid),
    .out_stall (div_stall),
    .ctl       (div_ctl),
    .quotient  (div_quotient)
  );

  // Blend of the two end colors.
  cgl_blend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (div_valid),
    .in_stall         (div_stall),
    .ctl              (div_ctl),
    .quotient         (div_quotient),
    .stop_colors_low  (stop_colors_low),
    .stop_colors_high (stop_colors_high),
    .out_valid        (color_valid),
    .out_stall        (color_stall),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .alpha            (alpha)
  );

endmodule
